FILE: src/cadp_pkg.sv
`default_nettype none
package cadp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  localparam logic [7:0] TagReset  = 8'h87;
  localparam logic [7:0] MinLength = 8'd3;
  localparam logic [7:0] CountMask = 8'h3f;
  localparam logic [7:0] ValueMask = 8'h0f;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_COUNT   = 3'd2,
    PH_REGION  = 3'd3,
    PH_DIMCNT  = 3'd4,
    PH_DIMID   = 3'd5,
    PH_DIMVAL  = 3'd6,
    PH_DESCLEN = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RATING     = 2'd0,
    KIND_REGION_END = 2'd1,
    KIND_EMPTY_DONE = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TAG       = 2'd1,
    ERR_LENGTH    = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] region_id;
    logic [7:0] dimension_id;
    logic [3:0] rating_value;
    logic [7:0] description_length;
    err_t       err;
    logic       last;
  } rec_t;

  function automatic rec_t make_rec(kind_t kind, logic [7:0] rid, logic [7:0] did,
                                    logic [3:0] val, logic [7:0] dlen, err_t err,
                                    logic last);
    rec_t r;
    r.kind               = kind;
    r.region_id          = rid;
    r.dimension_id       = did;
    r.rating_value       = val;
    r.description_length = dlen;
    r.err                = err;
    r.last               = last;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/content_advisory_descriptor_parser_top.sv
// Content advisory descriptor parser.
// The input channel takes one descriptor byte per item; in_start_of_descriptor
// marks the tag byte. The parser state is updated in the cycle the byte is
// accepted, and the zero, one or two result items the byte causes are written
// into a four-entry result queue that drives the output channel.
// A result item is registered into the queue when its byte is accepted. The block
// takes one byte per cycle as long as the receiver keeps up; a byte that produces
// two results (a region end or rating followed by a truncation error) writes both
// into the queue at once, and the queue absorbs the second.
// in_ready is high while the queue has room for two results, so a stalled
// receiver throttles the input once three or more results are queued.
// The configuration channel writes the expected tag and is always ready; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Synchronous reset empties the queue, sets the parser idle and restores the
// expected tag to 0x87.
`default_nettype none
module content_advisory_descriptor_parser_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_expected_tag,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_start_of_descriptor,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_record_kind,
  output logic [7:0]      out_region_id,
  output logic [7:0]      out_dimension_id,
  output logic [3:0]      out_rating_value,
  output logic [7:0]      out_description_length,
  output logic [1:0]      out_error_code,
  output logic            out_last_of_descriptor
);

  logic [7:0]        tag_r;
  cadp_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        pay_left_r, pay_left_nxt;
  logic [5:0]        reg_left_r, reg_left_nxt;
  logic [7:0]        cur_reg_r, cur_reg_nxt;
  logic [7:0]        dim_left_r, dim_left_nxt;
  logic [7:0]        cur_dim_r, cur_dim_nxt;
  logic [7:0]        desc_left_r, desc_left_nxt;

  cadp_pkg::rec_t    q_mem_r [cadp_pkg::QueueDepth];
  logic [cadp_pkg::QueueAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [cadp_pkg::QueueCw-1:0] count_r;

  logic              accept, pop;
  logic              p_vld, trunc;
  cadp_pkg::rec_t    p_rec, res0, res1;
  logic              res0_vld, res1_vld;
  logic [7:0]        pay_dec, dim_dec, desc_dec;
  logic [5:0]        reg_dec;
  logic [cadp_pkg::QueueCw-1:0] push_n;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = count_r <= cadp_pkg::QueueCw'(cadp_pkg::QueueDepth - 2);
  assign out_valid = count_r != '0;

  assign pay_dec  = pay_left_r - 8'd1;
  assign reg_dec  = reg_left_r - 6'd1;
  assign dim_dec  = dim_left_r - 8'd1;
  assign desc_dec = desc_left_r - 8'd1;

  always_comb begin
    phase_nxt     = phase_r;
    pay_left_nxt  = pay_left_r;
    reg_left_nxt  = reg_left_r;
    cur_reg_nxt   = cur_reg_r;
    dim_left_nxt  = dim_left_r;
    cur_dim_nxt   = cur_dim_r;
    desc_left_nxt = desc_left_r;
    p_vld         = 1'b0;
    p_rec         = cadp_pkg::make_rec(cadp_pkg::KIND_RATING, 8'd0, 8'd0, 4'd0, 8'd0,
                                       cadp_pkg::ERR_NONE, 1'b0);
    trunc         = 1'b0;
    if (in_start_of_descriptor) begin
      pay_left_nxt  = 8'd0;
      reg_left_nxt  = 6'd0;
      dim_left_nxt  = 8'd0;
      desc_left_nxt = 8'd0;
      if (in_data_byte != tag_r) begin
        p_vld     = 1'b1;
        p_rec     = cadp_pkg::make_rec(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0,
                                       cadp_pkg::ERR_TAG, 1'b1);
        phase_nxt = cadp_pkg::PH_IDLE;
      end else begin
        phase_nxt = cadp_pkg::PH_LEN;
      end
    end else begin
      case (phase_r)
        cadp_pkg::PH_IDLE: begin
        end
        cadp_pkg::PH_LEN: begin
          if (in_data_byte < cadp_pkg::MinLength) begin
            p_vld     = 1'b1;
            p_rec     = cadp_pkg::make_rec(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0,
                                           cadp_pkg::ERR_LENGTH, 1'b1);
            phase_nxt = cadp_pkg::PH_IDLE;
          end else begin
            pay_left_nxt = in_data_byte;
            phase_nxt    = cadp_pkg::PH_COUNT;
          end
        end
        default: begin
          pay_left_nxt = pay_dec;
          case (phase_r)
            cadp_pkg::PH_COUNT: begin
              reg_left_nxt = 6'(in_data_byte & cadp_pkg::CountMask);
              if ((in_data_byte & cadp_pkg::CountMask) == 8'd0) begin
                p_vld     = 1'b1;
                p_rec     = cadp_pkg::make_rec(cadp_pkg::KIND_EMPTY_DONE, 8'd0, 8'd0,
                                               4'd0, 8'd0, cadp_pkg::ERR_NONE, 1'b1);
                phase_nxt = cadp_pkg::PH_IDLE;
              end else begin
                phase_nxt = cadp_pkg::PH_REGION;
              end
            end
            cadp_pkg::PH_REGION: begin
              if (desc_left_r != 8'd0) begin
                desc_left_nxt = desc_dec;
                if (desc_dec == 8'd0 && reg_left_r == 6'd0) begin
                  phase_nxt = cadp_pkg::PH_IDLE;
                end
              end else if (reg_left_r == 6'd0) begin
                phase_nxt = cadp_pkg::PH_IDLE;
              end else begin
                cur_reg_nxt = in_data_byte;
                phase_nxt   = cadp_pkg::PH_DIMCNT;
              end
            end
            cadp_pkg::PH_DIMCNT: begin
              dim_left_nxt = in_data_byte;
              phase_nxt    = (in_data_byte == 8'd0) ? cadp_pkg::PH_DESCLEN
                                                    : cadp_pkg::PH_DIMID;
            end
            cadp_pkg::PH_DIMID: begin
              cur_dim_nxt = in_data_byte;
              phase_nxt   = cadp_pkg::PH_DIMVAL;
            end
            cadp_pkg::PH_DIMVAL: begin
              p_vld        = 1'b1;
              p_rec        = cadp_pkg::make_rec(cadp_pkg::KIND_RATING, cur_reg_r, cur_dim_r,
                                                4'(in_data_byte & cadp_pkg::ValueMask),
                                                8'd0, cadp_pkg::ERR_NONE, 1'b0);
              dim_left_nxt = dim_dec;
              phase_nxt    = (dim_dec == 8'd0) ? cadp_pkg::PH_DESCLEN : cadp_pkg::PH_DIMID;
            end
            default: begin
              reg_left_nxt = reg_dec;
              p_vld        = 1'b1;
              if (reg_dec == 6'd0 && in_data_byte <= pay_dec) begin
                p_rec     = cadp_pkg::make_rec(cadp_pkg::KIND_REGION_END, cur_reg_r, 8'd0,
                                               4'd0, in_data_byte, cadp_pkg::ERR_NONE, 1'b1);
                phase_nxt = cadp_pkg::PH_IDLE;
              end else begin
                p_rec         = cadp_pkg::make_rec(cadp_pkg::KIND_REGION_END, cur_reg_r,
                                                   8'd0, 4'd0, in_data_byte,
                                                   cadp_pkg::ERR_NONE, 1'b0);
                desc_left_nxt = in_data_byte;
                phase_nxt     = cadp_pkg::PH_REGION;
              end
            end
          endcase
          if (pay_dec == 8'd0 && phase_nxt != cadp_pkg::PH_IDLE) begin
            trunc     = 1'b1;
            phase_nxt = cadp_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res1     = cadp_pkg::make_rec(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0,
                                  cadp_pkg::ERR_TRUNCATED, 1'b1);
    res0     = p_vld ? p_rec : res1;
    res0_vld = accept && (p_vld || trunc);
    res1_vld = accept && p_vld && trunc;
    push_n   = cadp_pkg::QueueCw'(res0_vld) + cadp_pkg::QueueCw'(res1_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= cadp_pkg::TagReset;
      phase_r     <= cadp_pkg::PH_IDLE;
      pay_left_r  <= 8'd0;
      reg_left_r  <= 6'd0;
      cur_reg_r   <= 8'd0;
      dim_left_r  <= 8'd0;
      cur_dim_r   <= 8'd0;
      desc_left_r <= 8'd0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tag_r <= cfg_expected_tag;
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        pay_left_r  <= pay_left_nxt;
        reg_left_r  <= reg_left_nxt;
        cur_reg_r   <= cur_reg_nxt;
        dim_left_r  <= dim_left_nxt;
        cur_dim_r   <= cur_dim_nxt;
        desc_left_r <= desc_left_nxt;
      end
      wr_ptr_r <= wr_ptr_r + cadp_pkg::QueueAw'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cadp_pkg::QueueAw'(1);
      end
      count_r <= count_r + push_n - cadp_pkg::QueueCw'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res0_vld) begin
      q_mem_r[wr_ptr_r] <= res0;
    end
    if (res1_vld) begin
      q_mem_r[wr_ptr_r + cadp_pkg::QueueAw'(1)] <= res1;
    end
  end

  assign out_record_kind        = q_mem_r[rd_ptr_r].kind;
  assign out_region_id          = q_mem_r[rd_ptr_r].region_id;
  assign out_dimension_id       = q_mem_r[rd_ptr_r].dimension_id;
  assign out_rating_value       = q_mem_r[rd_ptr_r].rating_value;
  assign out_description_length = q_mem_r[rd_ptr_r].description_length;
  assign out_error_code         = q_mem_r[rd_ptr_r].err;
  assign out_last_of_descriptor = q_mem_r[rd_ptr_r].last;

endmodule
`default_nettype wire

FILE: src/cadp_checker.sv
`default_nettype none
module cadp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_record_kind,
  input wire logic [7:0] out_dimension_id,
  input wire logic [3:0] out_rating_value,
  input wire logic [1:0] out_error_code,
  input wire logic       out_last_of_descriptor
);

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item visible right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn while stalled");

  // An error always closes its descriptor and carries a nonzero code.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == cadp_pkg::KIND_ERROR |->
      out_last_of_descriptor && out_error_code != cadp_pkg::ERR_NONE)
    else $error("error item without last flag or code");

  // Rating items never end a descriptor and never carry an error code.
  a_rating_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == cadp_pkg::KIND_RATING |->
      !out_last_of_descriptor && out_error_code == cadp_pkg::ERR_NONE)
    else $error("malformed rating item");

  // Only rating items carry a dimension or value.
  a_nonrating_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != cadp_pkg::KIND_RATING |->
      out_dimension_id == 8'd0 && out_rating_value == 4'd0)
    else $error("dimension fields set on a non-rating item");

endmodule

bind content_advisory_descriptor_parser_top cadp_checker u_cadp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_record_kind        (out_record_kind),
  .out_dimension_id       (out_dimension_id),
  .out_rating_value       (out_rating_value),
  .out_error_code         (out_error_code),
  .out_last_of_descriptor (out_last_of_descriptor)
);
`default_nettype wire

FILE: verif/tb_content_advisory_descriptor_parser_top.sv
module tb_content_advisory_descriptor_parser_top;

  localparam int IdleLimit = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } desc_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_expected_tag;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_start_of_descriptor;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_record_kind;
  logic [7:0] out_region_id;
  logic [7:0] out_dimension_id;
  logic [3:0] out_rating_value;
  logic [7:0] out_description_length;
  logic [1:0] out_error_code;
  logic       out_last_of_descriptor;

  desc_byte_t       pending_bytes[$];
  cadp_pkg::rec_t   expected_records[$];
  int         error_count = 0;
  int         bytes_taken = 0;
  int         idle_cycles = 0;
  int         hold_left = 0;
  int         holds_taken = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         send_calm = 0;
  int         recv_calm = 0;

  cadp_pkg::phase_t parser_state = cadp_pkg::PH_IDLE;
  logic [7:0] accept_tag = cadp_pkg::TagReset;
  logic [7:0] payload_to_go = '0;
  logic [5:0] regions_to_go = '0;
  logic [7:0] cur_region_id = '0;
  logic [7:0] dims_to_go = '0;
  logic [7:0] cur_dim_id = '0;
  logic [7:0] desc_to_skip = '0;

  content_advisory_descriptor_parser_top u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_expected_tag       (cfg_expected_tag),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_data_byte           (in_data_byte),
    .in_start_of_descriptor (in_start_of_descriptor),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_record_kind        (out_record_kind),
    .out_region_id          (out_region_id),
    .out_dimension_id       (out_dimension_id),
    .out_rating_value       (out_rating_value),
    .out_description_length (out_description_length),
    .out_error_code         (out_error_code),
    .out_last_of_descriptor (out_last_of_descriptor)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("error at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic push_record(input cadp_pkg::kind_t kind, input logic [7:0] rid,
                             input logic [7:0] did, input logic [3:0] val,
                             input logic [7:0] dlen, input cadp_pkg::err_t err,
                             input logic last);
    cadp_pkg::rec_t r;
    r.kind               = kind;
    r.region_id          = rid;
    r.dimension_id       = did;
    r.rating_value       = val;
    r.description_length = dlen;
    r.err                = err;
    r.last               = last;
    expected_records.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start);
    if (start) begin
      payload_to_go = '0;
      regions_to_go = '0;
      dims_to_go    = '0;
      desc_to_skip  = '0;
      if (b != accept_tag) begin
        push_record(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0, cadp_pkg::ERR_TAG, 1'b1);
        parser_state = cadp_pkg::PH_IDLE;
      end else begin
        parser_state = cadp_pkg::PH_LEN;
      end
    end else if (parser_state == cadp_pkg::PH_LEN) begin
      if (b < cadp_pkg::MinLength) begin
        push_record(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0, cadp_pkg::ERR_LENGTH,
                    1'b1);
        parser_state = cadp_pkg::PH_IDLE;
      end else begin
        payload_to_go = b;
        parser_state  = cadp_pkg::PH_COUNT;
      end
    end else if (parser_state != cadp_pkg::PH_IDLE) begin
      payload_to_go = payload_to_go - 8'd1;
      case (parser_state)
        cadp_pkg::PH_COUNT: begin
          regions_to_go = 6'(b & cadp_pkg::CountMask);
          if (regions_to_go == 0) begin
            push_record(cadp_pkg::KIND_EMPTY_DONE, 8'd0, 8'd0, 4'd0, 8'd0,
                        cadp_pkg::ERR_NONE, 1'b1);
            parser_state = cadp_pkg::PH_IDLE;
          end else begin
            parser_state = cadp_pkg::PH_REGION;
          end
        end
        cadp_pkg::PH_REGION: begin
          if (desc_to_skip != 0) begin
            desc_to_skip = desc_to_skip - 8'd1;
            if (desc_to_skip == 0 && regions_to_go == 0) parser_state = cadp_pkg::PH_IDLE;
          end else if (regions_to_go == 0) begin
            parser_state = cadp_pkg::PH_IDLE;
          end else begin
            cur_region_id = b;
            parser_state  = cadp_pkg::PH_DIMCNT;
          end
        end
        cadp_pkg::PH_DIMCNT: begin
          dims_to_go   = b;
          parser_state = (b == 0) ? cadp_pkg::PH_DESCLEN : cadp_pkg::PH_DIMID;
        end
        cadp_pkg::PH_DIMID: begin
          cur_dim_id   = b;
          parser_state = cadp_pkg::PH_DIMVAL;
        end
        cadp_pkg::PH_DIMVAL: begin
          push_record(cadp_pkg::KIND_RATING, cur_region_id, cur_dim_id,
                      4'(b & cadp_pkg::ValueMask), 8'd0, cadp_pkg::ERR_NONE, 1'b0);
          dims_to_go   = dims_to_go - 8'd1;
          parser_state = (dims_to_go == 0) ? cadp_pkg::PH_DESCLEN : cadp_pkg::PH_DIMID;
        end
        default: begin
          regions_to_go = regions_to_go - 6'd1;
          if (regions_to_go == 0 && b <= payload_to_go) begin
            push_record(cadp_pkg::KIND_REGION_END, cur_region_id, 8'd0, 4'd0, b,
                        cadp_pkg::ERR_NONE, 1'b1);
            parser_state = cadp_pkg::PH_IDLE;
          end else begin
            push_record(cadp_pkg::KIND_REGION_END, cur_region_id, 8'd0, 4'd0, b,
                        cadp_pkg::ERR_NONE, 1'b0);
            desc_to_skip = b;
            parser_state = cadp_pkg::PH_REGION;
          end
        end
      endcase
      if (payload_to_go == 0 && parser_state != cadp_pkg::PH_IDLE) begin
        push_record(cadp_pkg::KIND_ERROR, 8'd0, 8'd0, 4'd0, 8'd0, cadp_pkg::ERR_TRUNCATED,
                    1'b1);
        parser_state = cadp_pkg::PH_IDLE;
      end
    end
  endtask

  task automatic push_byte(input logic [7:0] data, input logic start);
    desc_byte_t item;
    item.data  = data;
    item.start = start;
    pending_bytes.push_back(item);
  endtask

  task automatic queue_descriptor(input logic [7:0] tag);
    logic [7:0]  body[$];
    int          n_regions;
    int          n_dims;
    int          d_len;
    int          mode;
    int          extra;
    int          cut;
    int unsigned len;
    n_regions = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
    body.push_back({2'($urandom), 6'(n_regions)});
    repeat (n_regions) begin
      body.push_back(8'($urandom));
      n_dims = $urandom_range(0, 3);
      body.push_back(8'(n_dims));
      repeat (n_dims) begin
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
      end
      d_len = $urandom_range(0, 4);
      body.push_back(8'(d_len));
      repeat (d_len) body.push_back(8'($urandom));
    end
    len = (body.size() < 3) ? 3 : body.size();
    mode = $urandom_range(0, 11);
    case (mode)
      0, 1: len = $urandom_range(3, len);
      2: begin
        extra = $urandom_range(1, 4);
        len += extra;
        repeat (extra) body.push_back(8'($urandom));
      end
      3: repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
      4: len = $urandom_range(0, 255);
      5: len = $urandom_range(0, 2);
      6: begin
        cut = $urandom_range(0, body.size() - 1);
        while (body.size() > cut) void'(body.pop_back());
      end
      default: ;
    endcase
    push_byte(tag, 1'b1);
    if (mode != 6 || body.size() != 0 || $urandom_range(0, 1) == 1) push_byte(8'(len), 1'b0);
    foreach (body[i]) push_byte(body[i], 1'b0);
  endtask

  task automatic queue_random_bytes(input int n_bytes);
    int target;
    target = pending_bytes.size() + n_bytes;
    while (pending_bytes.size() < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        queue_descriptor(($urandom_range(0, 9) == 0) ? 8'($urandom) : accept_tag);
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tag(input logic [7:0] tag);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_expected_tag <= tag;
    do @(posedge clk);
    while (!cfg_ready);
    accept_tag = tag;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    desc_byte_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte, in_start_of_descriptor);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          item = pending_bytes.pop_front();
          in_data_byte           <= item.data;
          in_start_of_descriptor <= item.start;
          in_valid               <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver holds off twice for a long stretch while bytes keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left   <= 0;
      holds_taken <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_taken < 2 && bytes_taken >= 200 + 260 * holds_taken) begin
      hold_left   <= 90;
      holds_taken <= holds_taken + 1;
    end
  end

  always @(posedge clk) begin : monitor
    cadp_pkg::rec_t got;
    cadp_pkg::rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind               = cadp_pkg::kind_t'(out_record_kind);
        got.region_id          = out_region_id;
        got.dimension_id       = out_dimension_id;
        got.rating_value       = out_rating_value;
        got.description_length = out_description_length;
        got.err                = cadp_pkg::err_t'(out_error_code);
        got.last               = out_last_of_descriptor;
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("unexpected result item, kind %0d", got.kind));
        end else begin
          want = expected_records.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("record_kind %0d, expected %0d", got.kind, want.kind));
          if (got.region_id !== want.region_id)
            report_mismatch($sformatf("region_id %0d, expected %0d",
                                      got.region_id, want.region_id));
          if (got.dimension_id !== want.dimension_id)
            report_mismatch($sformatf("dimension_id %0d, expected %0d",
                                      got.dimension_id, want.dimension_id));
          if (got.rating_value !== want.rating_value)
            report_mismatch($sformatf("rating_value %0d, expected %0d",
                                      got.rating_value, want.rating_value));
          if (got.description_length !== want.description_length)
            report_mismatch($sformatf("description_length %0d, expected %0d",
                                      got.description_length, want.description_length));
          if (got.err !== want.err)
            report_mismatch($sformatf("error_code %0d, expected %0d", got.err, want.err));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_of_descriptor %0d, expected %0d",
                                      got.last, want.last));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("content_advisory_descriptor_parser_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_valid              = 1'b0;
    cfg_expected_tag       = 8'd0;
    in_valid               = 1'b0;
    in_data_byte           = 8'd0;
    in_start_of_descriptor = 1'b0;
    out_ready              = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_byte(8'h55, 1'b0);
    push_byte(8'h86, 1'b1);
    push_byte(8'h87, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(8'h87, 1'b1);
    push_byte(8'h03, 1'b0);
    push_byte(8'hc0, 1'b0);
    push_byte(8'h87, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h87, 1'b1);
    push_byte(8'h03, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h87, 1'b1);
    push_byte(8'h05, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte(8'h87, 1'b1);
    push_byte(8'h0a, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    write_tag(8'h00);
    queue_random_bytes(160);
    wait_idle();
    write_tag(8'hff);
    queue_random_bytes(160);
    wait_idle();
    write_tag(8'($urandom));
    queue_random_bytes(150);
    wait_idle();
    write_tag(cadp_pkg::TagReset);
    queue_random_bytes(150);
    wait_idle();
    repeat (8) @(negedge clk);

    if (expected_records.size() != 0)
      report_mismatch($sformatf("%0d result items never arrived", expected_records.size()));
    if (error_count == 0) begin
      $display("content_advisory_descriptor_parser_top: match");
    end else begin
      $display("content_advisory_descriptor_parser_top: mismatch");
    end
    $finish;
  end

endmodule
